// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clock and a reset named reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge out of reset
`define HCB_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// trigger implies consequence in the same cycle
`define HCB_IMPLIES(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) else $error(msg);
`endif

// File: sv/hcb_pkg.sv
// Constants and types for the Huffman code builder.
// Depends on nothing; used by huffman_code_builder_top.
package hcb_pkg;
   localparam int MAX_SYMBOLS = 64;
   localparam int NODE_CAP    = 2 * MAX_SYMBOLS - 1;
   localparam int INNER_CAP   = MAX_SYMBOLS - 1;
   localparam int IDX_W       = 7;
   localparam int SLOT_W      = 6;
   localparam int SYM_W       = 8;
   localparam int IN_WEIGHT_W = 24;
   localparam int WEIGHT_W    = 30;
   localparam int CODE_W      = 63;
   localparam int LEN_W       = 6;

   typedef enum logic [10:0] {
      ST_LOAD      = 11'b000_0000_0001,
      ST_SCAN      = 11'b000_0000_0010,
      ST_SCAN_END  = 11'b000_0000_0100,
      ST_PICK      = 11'b000_0000_1000,
      ST_WALK_INIT = 11'b000_0001_0000,
      ST_POP       = 11'b000_0010_0000,
      ST_POPD      = 11'b000_0100_0000,
      ST_KID       = 11'b000_1000_0000,
      ST_KID2      = 11'b001_0000_0000,
      ST_EMIT      = 11'b010_0000_0000,
      ST_SPARE     = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]  node;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } stk_type;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } kid_type;
endpackage

// File: sv/huffman_code_builder_top.sv
// Huffman code builder: loads (symbol, weight) words, builds the tree, emits codes.
// Loading takes one word per cycle while in the load state; each merge runs two weight-memory scans.
// Walk: a leaf steps through POP, POPD and EMIT; an inner node through POP, POPD, KID and KID2.
// EMIT waits while the result is held. One set at a time: loading resumes after the last code.
// Reset: synchronous, clears control, live bits and fill count; memories need no clearing.
// Depends on hcb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module huffman_code_builder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // symbol[7:0], weight[31:8]
   input  logic        req_tlast,   // final_symbol
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // leaf_symbol[7:0], code_bits[70:8], code_length[76:71]
   output logic        rsp_tlast    // final_code
);
   localparam logic [hcb_pkg::IDX_W-1:0] MAX_CNT = hcb_pkg::IDX_W'(hcb_pkg::MAX_SYMBOLS);

   hcb_pkg::state_type state_ff, state_in;
   logic [hcb_pkg::IDX_W-1:0]    loaded_ff, loaded_in;
   logic [hcb_pkg::NODE_CAP-1:0] live_ff, live_in;
   logic [hcb_pkg::IDX_W-1:0]    total_ff, total_in;
   logic [hcb_pkg::SLOT_W-1:0]   m_ff, m_in;
   logic [hcb_pkg::IDX_W-1:0]    scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic [hcb_pkg::IDX_W-1:0]    pidx_ff, pidx_in;
   logic                         found_ff, found_in;
   logic [hcb_pkg::IDX_W-1:0]    best_ff, best_in;
   logic [hcb_pkg::WEIGHT_W-1:0] bestw_ff, bestw_in;
   logic                         phase_b_ff, phase_b_in;
   logic [hcb_pkg::IDX_W-1:0]    a_ff, a_in;
   logic [hcb_pkg::WEIGHT_W-1:0] wa_ff, wa_in;
   logic [hcb_pkg::IDX_W-1:0]    sp_ff, sp_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [hcb_pkg::SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;
   logic [hcb_pkg::CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [hcb_pkg::LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   // memories and their read registers
   logic [hcb_pkg::WEIGHT_W-1:0] weight_mem [0:hcb_pkg::NODE_CAP-1];
   logic [hcb_pkg::SYM_W-1:0]    char_mem   [0:hcb_pkg::MAX_SYMBOLS-1];
   hcb_pkg::kid_type             kid_mem    [0:hcb_pkg::INNER_CAP-1];
   hcb_pkg::stk_type             stk_mem    [0:hcb_pkg::MAX_SYMBOLS-1];
   logic [hcb_pkg::WEIGHT_W-1:0] wrd_ff;
   logic [hcb_pkg::SYM_W-1:0]    crd_ff;
   hcb_pkg::kid_type             krd_ff;
   hcb_pkg::stk_type             srd_ff;

   logic                         w_we, w_re;
   logic [hcb_pkg::IDX_W-1:0]    w_waddr;
   logic [hcb_pkg::WEIGHT_W-1:0] w_wdata;
   logic                         c_we, c_re;
   logic [hcb_pkg::SLOT_W-1:0]   c_waddr, c_raddr;
   logic                         k_we, k_re;
   logic [hcb_pkg::SLOT_W-1:0]   k_waddr, k_raddr;
   hcb_pkg::kid_type             k_wdata;
   logic                         s_we, s_re;
   logic [hcb_pkg::SLOT_W-1:0]   s_waddr, s_raddr;
   hcb_pkg::stk_type             s_wdata;

   logic                         req_accept;
   logic [hcb_pkg::IDX_W-1:0]    n_after;
   logic [hcb_pkg::IDX_W-1:0]    sp_dec, sp_inc;
   logic [hcb_pkg::IDX_W-1:0]    kid_slot;
   logic [hcb_pkg::LEN_W-1:0]    len_inc;

   assign req_tready = (state_ff == hcb_pkg::ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign n_after    = (loaded_ff < MAX_CNT) ? loaded_ff + 7'd1 : loaded_ff;
   assign sp_dec     = sp_ff - 7'd1;
   assign sp_inc     = sp_ff + 7'd1;
   assign kid_slot   = srd_ff.node - loaded_ff;
   assign len_inc    = srd_ff.len + 6'd1;

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      live_in       = live_ff;
      total_in      = total_ff;
      m_in          = m_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bestw_in      = bestw_ff;
      phase_b_in    = phase_b_ff;
      a_in          = a_ff;
      wa_in         = wa_ff;
      sp_in         = sp_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      w_we = 1'b0; w_re = 1'b0; w_waddr = loaded_ff; w_wdata = '0;
      c_we = 1'b0; c_re = 1'b0; c_waddr = loaded_ff[5:0]; c_raddr = srd_ff.node[5:0];
      k_we = 1'b0; k_re = 1'b0; k_waddr = m_ff; k_raddr = kid_slot[5:0];
      k_wdata = '{left: a_ff, right: best_ff};
      s_we = 1'b0; s_re = 1'b0; s_waddr = sp_ff[5:0]; s_raddr = sp_dec[5:0];
      s_wdata = '0;

      // compare stage of the scan: strict less keeps the earliest node on ties
      if (pend_ff && (!found_ff || wrd_ff < bestw_ff)) begin
         best_in  = pidx_ff;
         bestw_in = wrd_ff;
         found_in = 1'b1;
      end

      unique case (state_ff)
         hcb_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (loaded_ff < MAX_CNT) begin
                  w_we    = 1'b1;
                  w_wdata = hcb_pkg::WEIGHT_W'(req_tdata[31:8]);
                  c_we    = 1'b1;
                  live_in[loaded_ff] = 1'b1;
                  loaded_in = loaded_ff + 7'd1;
               end
               if (req_tlast) begin
                  total_in   = n_after;
                  m_in       = '0;
                  phase_b_in = 1'b0;
                  scan_in    = '0;
                  found_in   = 1'b0;
                  state_in   = (n_after > 7'd1) ? hcb_pkg::ST_SCAN : hcb_pkg::ST_WALK_INIT;
               end
            end
         end
         hcb_pkg::ST_SCAN: begin
            if (scan_ff < total_ff) begin
               w_re    = 1'b1;
               pend_in = live_ff[scan_ff];
               pidx_in = scan_ff;
               scan_in = scan_ff + 7'd1;
            end else begin
               state_in = hcb_pkg::ST_SCAN_END;
            end
         end
         hcb_pkg::ST_SCAN_END: begin
            state_in = hcb_pkg::ST_PICK;
         end
         hcb_pkg::ST_PICK: begin
            live_in[best_ff] = 1'b0;
            scan_in  = '0;
            found_in = 1'b0;
            if (!phase_b_ff) begin
               a_in       = best_ff;
               wa_in      = bestw_ff;
               phase_b_in = 1'b1;
               state_in   = hcb_pkg::ST_SCAN;
            end else begin
               w_we    = 1'b1;
               w_waddr = total_ff;
               w_wdata = wa_ff + bestw_ff;
               k_we    = 1'b1;
               live_in[total_ff] = 1'b1;
               total_in   = total_ff + 7'd1;
               m_in       = m_ff + 6'd1;
               phase_b_in = 1'b0;
               state_in   = (({1'b0, m_ff} + 7'd2) < loaded_ff) ?
                            hcb_pkg::ST_SCAN : hcb_pkg::ST_WALK_INIT;
            end
         end
         hcb_pkg::ST_WALK_INIT: begin
            s_we     = 1'b1;
            s_waddr  = '0;
            s_wdata  = '{node: total_ff - 7'd1, len: '0, code: '0};
            sp_in    = 7'd1;
            state_in = hcb_pkg::ST_POP;
         end
         hcb_pkg::ST_POP: begin
            s_re     = 1'b1;
            sp_in    = sp_dec;
            state_in = hcb_pkg::ST_POPD;
         end
         hcb_pkg::ST_POPD: begin
            // leaves hold the indices below the symbol count
            if (srd_ff.node < loaded_ff) begin
               c_re     = 1'b1;
               state_in = hcb_pkg::ST_EMIT;
            end else begin
               k_re     = 1'b1;
               state_in = hcb_pkg::ST_KID;
            end
         end
         hcb_pkg::ST_KID: begin
            s_we     = 1'b1;
            s_wdata  = '{node: krd_ff.right, len: len_inc, code: {srd_ff.code[61:0], 1'b1}};
            state_in = hcb_pkg::ST_KID2;
         end
         hcb_pkg::ST_KID2: begin
            s_we     = 1'b1;
            s_waddr  = sp_inc[5:0];
            s_wdata  = '{node: krd_ff.left, len: len_inc, code: {srd_ff.code[61:0], 1'b0}};
            sp_in    = sp_ff + 7'd2;
            state_in = hcb_pkg::ST_POP;
         end
         hcb_pkg::ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_sym_in    = crd_ff;
               rsp_code_in   = srd_ff.code;
               rsp_len_in    = srd_ff.len;
               rsp_last_in   = (sp_ff == 7'd0);
               if (sp_ff == 7'd0) begin
                  live_in   = '0;
                  loaded_in = '0;
                  state_in  = hcb_pkg::ST_LOAD;
               end else begin
                  state_in  = hcb_pkg::ST_POP;
               end
            end
         end
         default: begin
            state_in = hcb_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hcb_pkg::ST_LOAD;
         loaded_ff     <= '0;
         live_ff       <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         phase_b_ff    <= 1'b0;
         sp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         live_ff       <= live_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         phase_b_ff    <= phase_b_in;
         sp_ff         <= sp_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff    <= total_in;
      m_ff        <= m_in;
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      best_ff     <= best_in;
      bestw_ff    <= bestw_in;
      a_ff        <= a_in;
      wa_ff       <= wa_in;
      rsp_last_ff <= rsp_last_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_code_ff <= rsp_code_in;
      rsp_len_ff  <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_waddr] <= w_wdata;
      if (w_re) wrd_ff <= weight_mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (c_we) char_mem[c_waddr] <= req_tdata[7:0];
      if (c_re) crd_ff <= char_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (k_we) kid_mem[k_waddr] <= k_wdata;
      if (k_re) krd_ff <= kid_mem[k_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) stk_mem[s_waddr] <= s_wdata;
      if (s_re) srd_ff <= stk_mem[s_raddr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_code_ff, rsp_sym_ff};

   `HCB_ALWAYS(a_loaded_cap, loaded_ff <= MAX_CNT, "symbol count beyond capacity")
   `HCB_ALWAYS(a_stack_cap, sp_ff <= MAX_CNT, "walk stack overflow")
   `HCB_IMPLIES(a_merge_count, state_ff == hcb_pkg::ST_SCAN,
                ({1'b0, m_ff} + 7'd1) < loaded_ff, "scan with no merge left")
   `HCB_IMPLIES(a_pop_nonempty, state_ff == hcb_pkg::ST_POP, sp_ff != 7'd0,
                "pop from empty walk stack")
endmodule
